// ===== sv/rrwa_pkg.sv =====
// ----------------------------------------------------------------------------
// rrwa_pkg
// Types, codes and sizes shared by the round-robin worker assigner.
// ----------------------------------------------------------------------------
package rrwa_pkg;

   localparam int MAX_WORKERS = 8;
   localparam int IDX_W       = $clog2(MAX_WORKERS);
   localparam int CNT_W       = $clog2(MAX_WORKERS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CMD_W    = 2;
   localparam int WID_W    = 8;
   localparam int STAT_W   = 2;
   localparam int CODE_W   = 3;
   localparam int ID_W     = 4;
   localparam int TASK_W   = 16;
   localparam int TOTAL_W  = 4;
   localparam int ASSIGN_W = 16;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd2;

   localparam logic [STAT_W-1:0] ST_AVAILABLE = 2'd0;
   localparam logic [STAT_W-1:0] ST_BUSY      = 2'd1;
   localparam logic [STAT_W-1:0] ST_MAINT     = 2'd2;

   localparam logic [CODE_W-1:0] RC_OK       = 3'd0;
   localparam logic [CODE_W-1:0] RC_FULL     = 3'd1;
   localparam logic [CODE_W-1:0] RC_EMPTY    = 3'd2;
   localparam logic [CODE_W-1:0] RC_NONE     = 3'd3;
   localparam logic [CODE_W-1:0] RC_NOTFOUND = 3'd4;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_ASSIGN,
      OP_SET,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [WID_W-1:0]  worker_id;
      logic [STAT_W-1:0] new_status;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]   result_code;
      logic [ID_W-1:0]     chosen_id;
      logic [TASK_W-1:0]   chosen_tasks;
      logic [TOTAL_W-1:0]  worker_total;
      logic [ASSIGN_W-1:0] assignment_total;
   } rsp_type;

   // classified word passed from the front end to the back end
   typedef struct packed {
      op_type            op;
      logic [WID_W-1:0]  worker_id;
      logic [STAT_W-1:0] status;
   } op_item_type;

endpackage

// ===== sv/rrwa_front.sv =====
// ----------------------------------------------------------------------------
// rrwa_front
// Accepts request words and classifies them into back-end operations.
// ----------------------------------------------------------------------------
module rrwa_front import rrwa_pkg::*; (
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        push_valid,
   input  logic        push_ready,
   output op_item_type push_item
);

   op_item_type item;

   always_comb begin
      item.worker_id = req_data.worker_id;
      case (req_data.command)
         CMD_ADD:    item.op = OP_ADD;
         CMD_ASSIGN: item.op = OP_ASSIGN;
         CMD_SET:    item.op = OP_SET;
         default:    item.op = OP_BAD;
      endcase
      // fold the unused status code into maintenance
      case (req_data.new_status)
         ST_AVAILABLE: item.status = ST_AVAILABLE;
         ST_BUSY:      item.status = ST_BUSY;
         default:      item.status = ST_MAINT;
      endcase
   end

   assign push_valid = req_valid && !reset;
   assign req_ready  = push_ready && !reset;
   assign push_item  = item;

endmodule

// ===== sv/rrwa_queue.sv =====
// ----------------------------------------------------------------------------
// rrwa_queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module rrwa_queue import rrwa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  op_item_type push_item,
   output logic        pop_valid,
   input  logic        pop_ready,
   output op_item_type pop_item
);

   op_item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/rrwa_back.sv =====
// ----------------------------------------------------------------------------
// rrwa_back
// Worker table, round-robin search and registered result word.
// ----------------------------------------------------------------------------
module rrwa_back import rrwa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  op_item_type pop_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   logic [STAT_W-1:0]   status_ff [MAX_WORKERS];
   logic [TASK_W-1:0]   tasks_ff  [MAX_WORKERS];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    rr_ff, rr_in;
   logic [ASSIGN_W-1:0] total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                pop;
   logic [MAX_WORKERS-1:0] avail, avail_hi;
   logic [IDX_W-1:0]    hi_idx, lo_idx, pick_idx, set_idx, rd_idx;
   logic                found, set_hit, full;
   logic [CNT_W-1:0]    pick_next;
   logic [TASK_W-1:0]   rd_tasks, rd_tasks_inc;
   logic                st_we, tk_we;
   logic [IDX_W-1:0]    wr_idx;
   logic [STAT_W-1:0]   st_wdata;
   logic [TASK_W-1:0]   tk_wdata;

   assign pop       = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // availability mask, and the part of it at or past the pointer
   always_comb begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
         avail[i]    = (status_ff[i] == ST_AVAILABLE) && (CNT_W'(i) < count_ff);
         avail_hi[i] = avail[i] && (IDX_W'(i) >= rr_ff);
      end
   end

   // lowest set bit of each mask; wrap to the low mask when nothing is past the pointer
   always_comb begin
      hi_idx = '0;
      lo_idx = '0;
      for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
         if (avail_hi[i]) begin
            hi_idx = IDX_W'(i);
         end
         if (avail[i]) begin
            lo_idx = IDX_W'(i);
         end
      end
   end

   assign found     = |avail;
   assign pick_idx  = (|avail_hi) ? hi_idx : lo_idx;
   assign pick_next = {1'b0, pick_idx} + 1'b1;
   assign full      = (count_ff == CNT_W'(MAX_WORKERS));

   assign set_hit = (pop_item.worker_id != '0) &&
                    (pop_item.worker_id <= WID_W'(count_ff));
   assign set_idx = IDX_W'(pop_item.worker_id - 1'b1);

   assign rd_idx       = (pop_item.op == OP_ASSIGN) ? pick_idx : set_idx;
   assign rd_tasks     = tasks_ff[rd_idx];
   assign rd_tasks_inc = (rd_tasks == '1) ? rd_tasks : rd_tasks + 1'b1;

   always_comb begin
      count_in     = count_ff;
      rr_in        = rr_ff;
      total_in     = total_ff;
      st_we        = 1'b0;
      tk_we        = 1'b0;
      wr_idx       = rd_idx;
      st_wdata     = pop_item.status;
      tk_wdata     = rd_tasks_inc;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (pop) begin
         rsp_valid_in             = 1'b1;
         rsp_in.result_code       = RC_NOTFOUND;
         rsp_in.chosen_id         = '0;
         rsp_in.chosen_tasks      = '0;
         case (pop_item.op)
            OP_ADD: begin
               if (full) begin
                  rsp_in.result_code = RC_FULL;
               end else begin
                  st_we              = 1'b1;
                  tk_we              = 1'b1;
                  wr_idx             = IDX_W'(count_ff);
                  st_wdata           = ST_AVAILABLE;
                  tk_wdata           = '0;
                  count_in           = count_ff + 1'b1;
                  rsp_in.result_code = RC_OK;
                  rsp_in.chosen_id   = ID_W'(count_ff + 1'b1);
               end
            end
            OP_ASSIGN: begin
               if (count_ff == '0) begin
                  rsp_in.result_code = RC_EMPTY;
               end else if (!found) begin
                  rsp_in.result_code = RC_NONE;
               end else begin
                  st_we               = 1'b1;
                  tk_we               = 1'b1;
                  wr_idx              = pick_idx;
                  st_wdata            = ST_BUSY;
                  tk_wdata            = rd_tasks_inc;
                  total_in            = (total_ff == '1) ? total_ff : total_ff + 1'b1;
                  rr_in               = (pick_next == count_ff) ? '0 : IDX_W'(pick_next);
                  rsp_in.result_code  = RC_OK;
                  rsp_in.chosen_id    = ID_W'(pick_next);
                  rsp_in.chosen_tasks = rd_tasks_inc;
               end
            end
            OP_SET: begin
               if (set_hit) begin
                  st_we               = 1'b1;
                  wr_idx              = set_idx;
                  st_wdata            = pop_item.status;
                  rsp_in.result_code  = RC_OK;
                  rsp_in.chosen_id    = ID_W'(pop_item.worker_id);
                  rsp_in.chosen_tasks = rd_tasks;
               end
            end
            default: begin
               rsp_in.result_code = RC_NOTFOUND;
            end
         endcase
         rsp_in.worker_total     = TOTAL_W'(count_in);
         rsp_in.assignment_total = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rr_ff        <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rr_ff        <= rr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (st_we) begin
         status_ff[wr_idx] <= st_wdata;
      end
      if (tk_we) begin
         tasks_ff[wr_idx] <= tk_wdata;
      end
   end

endmodule

// ===== sv/round_robin_worker_assigner.sv =====
// ----------------------------------------------------------------------------
// round_robin_worker_assigner
// Worker table with add, round-robin assign and set-status commands.
// ----------------------------------------------------------------------------
// A request word is accepted whenever the two-entry queue behind the front end
// has room; the back end executes one word per cycle while its result register
// is empty or being taken, so the sustained rate is one word per cycle. The
// accepted word is written into the queue; when the back end pops it, the
// table update runs and loads the result register, so the result word is
// presented from that register and waits there until it is taken. The
// round-robin search over all workers is a rotated priority encoder and
// completes in the same cycle as the table update. Results stall only the
// queue; the front end keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module round_robin_worker_assigner import rrwa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic        push_valid, push_ready;
   op_item_type push_item;
   logic        pop_valid, pop_ready;
   op_item_type pop_item;

   rrwa_front u_front (
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   rrwa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   rrwa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
